// ----- hdl/spq_pkg.sv -----
package spq_pkg;

  localparam int Depth     = 16;
  localparam int PrioW     = 16;
  localparam int PayW      = 32;
  localparam int CountOutW = 5;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [PrioW-1:0] prio;
    logic [PayW-1:0]         payload;
  } entry_t;

  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ent;
  } cell_ctrl_t;

endpackage

// ----- hdl/spq_cell.sv -----
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               occ,
  input  logic               p_left,
  input  spq_pkg::entry_t    left_ent,
  input  spq_pkg::entry_t    right_ent,
  output logic               p_here,
  output spq_pkg::entry_t    ent,
  output spq_pkg::entry_t    ent_next
);

  // at or past the insertion point
  assign p_here = !occ || (ent.prio >= ctrl.ent.prio);

  always_comb begin
    ent_next = ent;
    if (ctrl.enq) begin
      if (p_left) begin
        ent_next = left_ent;
      end else if (p_here) begin
        ent_next = ctrl.ent;
      end
    end else if (ctrl.deq) begin
      ent_next = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

// ----- hdl/sorted_priority_queue_unit.sv -----
// Channel  Dir  Bits  Contents
// s        in   48    s_tdata: priority_req[15:0], payload[47:16]; s_tuser: op
// m        out  72    accepted, removed_payload, head_payload, is_empty, entry_count
//
// One transaction per cycle: every cell compares its priority with the new one in
// parallel and shifts left, right or holds in the same edge.
// The result sits in an output register; a new transaction is taken while it is
// empty or being taken, so a stall on m holds s_tready low.
// Reset (rst, synchronous) empties the queue and drops any pending result.
module sorted_priority_queue_unit #(
  parameter int DEPTH = spq_pkg::Depth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // priority_req[15:0], payload[47:16]
  input  logic [0:0]  s_tuser,  // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata   // accepted, removed_payload, head_payload, is_empty,
                                // entry_count, zero pad
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int PayW = spq_pkg::PayW;
  localparam int CoW  = spq_pkg::CountOutW;

  logic [CntW-1:0]      count;
  logic [CntW-1:0]      count_next;
  logic [CntW+CoW-1:0]  count_ext;
  logic                 fire;
  spq_pkg::op_t         op;
  logic                 full;
  logic                 empty;
  logic                 do_enq;
  logic                 do_deq;
  spq_pkg::cell_ctrl_t  ctrl;

  logic                 pf       [DEPTH];
  spq_pkg::entry_t      ent      [DEPTH];
  spq_pkg::entry_t      ent_next [DEPTH];

  logic                 res_valid;
  logic                 res_accepted;
  logic [PayW-1:0]      res_removed;
  logic [PayW-1:0]      res_head;
  logic                 res_empty;
  logic [CoW-1:0]       res_count;

  assign s_tready = !res_valid || m_tready;
  assign fire     = s_tvalid && s_tready;
  assign op       = spq_pkg::op_t'(s_tuser);
  assign full     = count == CntW'(DEPTH);
  assign empty    = count == '0;
  assign do_enq   = fire && (op == spq_pkg::OP_ENQ) && !full;
  assign do_deq   = fire && (op == spq_pkg::OP_DEQ) && !empty;

  assign ctrl.enq         = do_enq;
  assign ctrl.deq         = do_deq;
  assign ctrl.ent.prio    = s_tdata[15:0];
  assign ctrl.ent.payload = s_tdata[47:16];

  always_comb begin
    count_next = count;
    if (do_enq) begin
      count_next = count + CntW'(1);
    end else if (do_deq) begin
      count_next = count - CntW'(1);
    end
  end

  assign count_ext = {{CoW{1'b0}}, count_next};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            p_left;
    spq_pkg::entry_t left_ent;
    spq_pkg::entry_t right_ent;

    if (i == 0) begin : g_first
      assign p_left   = 1'b0;
      assign left_ent = '0;
    end else begin : g_mid
      assign p_left   = pf[i-1];
      assign left_ent = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (count > CntW'(i)),
      .p_left    (p_left),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .p_here    (pf[i]),
      .ent       (ent[i]),
      .ent_next  (ent_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        res_valid <= 1'b1;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_accepted <= do_enq || do_deq;
      res_removed  <= do_deq ? ent[0].payload : '0;
      res_head     <= (count_next != '0) ? ent_next[0].payload : '0;
      res_empty    <= count_next == '0;
      res_count    <= count_ext[CoW-1:0];
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {1'b0, res_count, res_empty, res_head, res_removed, res_accepted};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("entry count exceeds depth");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    (fire && op == spq_pkg::OP_ENQ && !full) |=> (count == $past(count) + CntW'(1)))
    else $error("accepted enqueue did not grow the queue");

  a_deq_refused: assert property (@(posedge clk) disable iff (rst)
    (fire && op == spq_pkg::OP_DEQ && empty) |=> (!res_accepted && res_empty))
    else $error("dequeue on empty queue not refused");

  for (genvar k = 1; k < DEPTH; k++) begin : g_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      (count > CntW'(k)) |-> (ent[k-1].prio <= ent[k].prio))
      else $error("cell row out of order");
  end

endmodule

// ----- test/queue_checker.sv -----
`timescale 1ns / 1ps

module queue_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  output int          mismatches,
  output int          pending,
  output int          results_seen,
  output int          full_refusals,
  output int          empty_refusals
);

  typedef struct packed {
    logic                     accepted;
    logic [spq_pkg::PayW-1:0] removed;
    logic [spq_pkg::PayW-1:0] head;
    logic                     empty;
    logic [4:0]               count;
  } queue_result_t;

  spq_pkg::entry_t slots[spq_pkg::Depth];
  int              fill;
  queue_result_t   queue_results_q[$];
  int              errs;
  int              seen;
  int              fulls;
  int              empties;

  function automatic queue_result_t apply_op(spq_pkg::op_t op,
                                             logic signed [spq_pkg::PrioW-1:0] prio,
                                             logic [spq_pkg::PayW-1:0] pay);
    queue_result_t r;
    int            pos;
    r = '0;
    if (op == spq_pkg::OP_ENQ) begin
      if (fill < spq_pkg::Depth) begin
        pos = fill;
        for (int i = fill - 1; i >= 0; i--) begin
          if ($signed(slots[i].prio) >= prio) pos = i;
        end
        for (int i = fill; i > pos; i--) slots[i] = slots[i-1];
        slots[pos].prio    = prio;
        slots[pos].payload = pay;
        fill++;
        r.accepted = 1'b1;
      end
    end else if (fill > 0) begin
      r.removed = slots[0].payload;
      for (int i = 1; i < fill; i++) slots[i-1] = slots[i];
      fill--;
      r.accepted = 1'b1;
    end
    r.head  = (fill > 0) ? slots[0].payload : '0;
    r.empty = (fill == 0);
    r.count = 5'(fill);
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (rst) begin
      fill = 0;
      queue_results_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.accepted = m_tdata[0];
        got.removed  = m_tdata[32:1];
        got.head     = m_tdata[64:33];
        got.empty    = m_tdata[65];
        got.count    = m_tdata[70:66];
        seen++;
        if (queue_results_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected result acc=%0d rem=%h head=%h empty=%0d count=%0d",
                     $realtime, got.accepted, got.removed, got.head, got.empty, got.count);
        end else begin
          want = queue_results_q.pop_front();
          if (!want.accepted && want.empty) empties++;
          else if (!want.accepted) fulls++;
          if (got.accepted !== want.accepted || got.removed !== want.removed ||
              got.head !== want.head || got.empty !== want.empty ||
              got.count !== want.count) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: mismatch expected acc=%0d rem=%h head=%h empty=%0d count=%0d",
                       $realtime, want.accepted, want.removed, want.head, want.empty,
                       want.count);
              $display("%0t:          actual   acc=%0d rem=%h head=%h empty=%0d count=%0d",
                       $realtime, got.accepted, got.removed, got.head, got.empty,
                       got.count);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        queue_results_q.push_back(apply_op(spq_pkg::op_t'(s_tuser), s_tdata[15:0],
                                           s_tdata[47:16]));
    end
    mismatches     <= errs;
    pending        <= queue_results_q.size();
    results_seen   <= seen;
    full_refusals  <= fulls;
    empty_refusals <= empties;
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int ItemCount  = 1950;
  localparam int LongHold   = 400;
  localparam int CycleLimit = 500000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic [0:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;

  int mismatches;
  int pending;
  int results_seen;
  int full_refusals;
  int empty_refusals;
  int cycles      = 0;
  int burst_left  = 0;
  int items_sent  = 0;
  bit long_hold_req = 1'b0;

  always #5 clk = ~clk;

  sorted_priority_queue_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  queue_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatches     (mismatches),
    .pending        (pending),
    .results_seen   (results_seen),
    .full_refusals  (full_refusals),
    .empty_refusals (empty_refusals)
  );

  task automatic send_op(spq_pkg::op_t op, logic signed [spq_pkg::PrioW-1:0] prio,
                         logic [spq_pkg::PayW-1:0] pay);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {pay, prio};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // stimulus and verdict
  initial begin
    int                               n;
    int                               len;
    int                               enq_pct;
    int                               prio_mode;
    logic signed [spq_pkg::PrioW-1:0] prio;
    spq_pkg::op_t                     op;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_op(spq_pkg::OP_DEQ, 16'sh1234, 32'hDEADBEEF);
    send_op(spq_pkg::OP_ENQ, 16'sh0000, 32'h0000_0000);
    send_op(spq_pkg::OP_ENQ, 16'sh7FFF, 32'hFFFF_FFFF);
    send_op(spq_pkg::OP_ENQ, 16'sh8000, 32'h0000_0001);
    send_op(spq_pkg::OP_ENQ, 16'sh0000, 32'hA5A5_A5A5);
    send_op(spq_pkg::OP_ENQ, 16'shFFFF, 32'h5A5A_5A5A);
    send_op(spq_pkg::OP_ENQ, 16'sh8000, 32'h8000_0000);
    send_op(spq_pkg::OP_ENQ, 16'sh7FFF, 32'h7FFF_FFFF);
    for (int k = 0; k < 9; k++) send_op(spq_pkg::OP_ENQ, 16'(k % 3 - 1), 32'h100 + k);
    send_op(spq_pkg::OP_ENQ, 16'sh8000, 32'hCAFE_F00D);
    send_op(spq_pkg::OP_DEQ, 16'sh7FFF, 32'hFFFF_FFFF);
    send_op(spq_pkg::OP_DEQ, 16'sh8000, 32'h0000_0000);
    send_op(spq_pkg::OP_DEQ, 16'sh0000, 32'h1234_5678);
    send_op(spq_pkg::OP_DEQ, 16'shFFFF, 32'h8765_4321);

    n = 0;
    while (n < ItemCount) begin
      case ($urandom_range(0, 4))
        0:       enq_pct = 90;
        1:       enq_pct = 70;
        2:       enq_pct = 50;
        3:       enq_pct = 30;
        default: enq_pct = 10;
      endcase
      prio_mode = $urandom_range(0, 3);
      len       = $urandom_range(10, 60);
      for (int k = 0; k < len && n < ItemCount; k++) begin
        case (prio_mode)
          0: prio = 16'($urandom);
          1: prio = 16'($urandom_range(0, 4)) - 16'd2;
          2: begin
            case ($urandom_range(0, 3))
              0:       prio = 16'sh8000;
              1:       prio = 16'sh7FFF;
              2:       prio = 16'sh8001;
              default: prio = 16'sh7FFE;
            endcase
          end
          default: prio = 16'($urandom_range(0, 15) * 512) - 16'd4096;
        endcase
        op = ($urandom_range(1, 100) <= enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
        send_op(op, prio, $urandom);
        n++;
        if (n == 300) long_hold_req = 1'b1;
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results against the sorted queue predictor.",
             items_sent, results_seen);
    $display("Refused enqueues on a full queue: %0d, refused dequeues on an empty queue: %0d.",
             full_refusals, empty_refusals);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // receiver stall pattern, with one long hold-off to back up the input
  initial begin
    int  mode;
    int  len;
    bit  hold_done;
    hold_done = 1'b0;
    forever begin
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(5, 80);
        repeat (len) begin
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 9) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
